// ----- rtl/rse_pkg.sv -----
// ----------------------------------------------------------------------------
// rse_pkg: shared constants and types for the shuffle engine
// Store geometry, generator constants, and the command/status structs that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package rse_pkg;

	// data set geometry
	localparam int MAX_ITEMS    = 64;
	localparam int ELEMENT_BITS = 32;
	localparam int STORE_DEPTH  = 64;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);
	localparam int CNT_W        = ADDR_W + 1;
	localparam int ENTRY_W      = ELEMENT_BITS + ADDR_W;

	// port field widths
	localparam int VALUE_W = 32;
	localparam int INDEX_W = 6;
	localparam int SEED_W  = 48;

	// rand48 generator
	localparam int               RAND_BITS   = 31;
	localparam int               CHUNK_W     = 16;
	localparam int               LCG_CHUNKS  = SEED_W / CHUNK_W;
	localparam int               CHUNK_IDX_W = $clog2(LCG_CHUNKS);
	localparam int               MUL_W       = 35;
	localparam int               PROD_W      = CHUNK_W + MUL_W;
	localparam logic [MUL_W-1:0] LCG_MUL     = 35'h5DEECE66D;
	localparam logic [SEED_W-1:0] LCG_ADD    = 48'hB;
	localparam int               STEP_W      = $clog2(RAND_BITS);

	// controller -> datapath
	typedef struct packed {
		logic store;     // write the incoming element at the fill position
		logic prep;      // i <= n-1, k <= 0
		logic lcg_init;  // start a generator step
		logic lcg_step;  // add one partial product
		logic gen_load;  // commit new generator state, start the modulo
		logic mod_step;  // one restoring-division bit
		logic rd_i;      // read entry i
		logic rd_j;      // read entry j, hold entry i
		logic wr_i;      // entry i <= old entry j
		logic wr_j;      // entry j <= old entry i, i <= i-1
		logic rd_k;      // read entry k for output
		logic out_load;  // load output register, k <= k+1
		logic clr_count; // data set emitted
	} rse_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic i_zero;
		logic lcg_last;
		logic mod_last;
		logic k_last;
	} rse_sts_t;

endpackage

// ----- rtl/rse_ram.sv -----
// ----------------------------------------------------------------------------
// rse_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/rse_dp.sv -----
// ----------------------------------------------------------------------------
// rse_dp: shuffle engine datapath
// Generator, partial-product LCG step, bit-serial modulo, counters, element
// store and output register.
// ----------------------------------------------------------------------------
module rse_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rse_pkg::rse_cmd_t                cmd,
	output rse_pkg::rse_sts_t                sts,
	input  logic                             cfg_we,
	input  logic [rse_pkg::SEED_W-1:0]       cfg_seed,
	input  logic [rse_pkg::VALUE_W-1:0]      in_value,
	output logic [rse_pkg::VALUE_W-1:0]      out_value,
	output logic [rse_pkg::INDEX_W-1:0]      out_index,
	output logic                             out_last
);

	logic [rse_pkg::SEED_W-1:0]    gen_q;
	logic [rse_pkg::SEED_W-1:0]    acc_q;
	logic [rse_pkg::CNT_W-1:0]     count_q;
	logic [rse_pkg::ADDR_W-1:0]    i_q;
	logic [rse_pkg::ADDR_W-1:0]    k_q;
	logic [rse_pkg::ADDR_W-1:0]    rem_q;
	logic [rse_pkg::RAND_BITS-1:0] dvd_q;
	logic [rse_pkg::STEP_W-1:0]    step_q;
	logic [rse_pkg::ENTRY_W-1:0]   tmp_q;

	logic [rse_pkg::CHUNK_W-1:0]   chunk;
	logic [rse_pkg::PROD_W-1:0]    prod;
	logic [rse_pkg::SEED_W-1:0]    pp;
	logic [rse_pkg::ADDR_W:0]      trial;
	logic [rse_pkg::CNT_W-1:0]     divisor;
	logic [rse_pkg::ADDR_W-1:0]    rem_next;
	logic                          full;

	logic                          ram_we;
	logic [rse_pkg::ADDR_W-1:0]    ram_waddr;
	logic [rse_pkg::ENTRY_W-1:0]   ram_wdata;
	logic [rse_pkg::ADDR_W-1:0]    ram_raddr;
	logic [rse_pkg::ENTRY_W-1:0]   ram_rdata;

	// one 16-bit slice of the state times the multiplier per cycle
	always_comb begin
		chunk = gen_q[rse_pkg::CHUNK_W * int'(step_q[rse_pkg::CHUNK_IDX_W-1:0]) +:
			rse_pkg::CHUNK_W];
		prod  = rse_pkg::PROD_W'(chunk) * rse_pkg::PROD_W'(rse_pkg::LCG_MUL);
		pp    = rse_pkg::SEED_W'(prod << (rse_pkg::CHUNK_W *
			int'(step_q[rse_pkg::CHUNK_IDX_W-1:0])));
	end

	// restoring division, one dividend bit per cycle; divisor is i+1
	always_comb begin
		divisor  = rse_pkg::CNT_W'(i_q) + rse_pkg::CNT_W'(1);
		trial    = {rem_q, dvd_q[rse_pkg::RAND_BITS-1]};
		rem_next = (trial >= divisor) ? rse_pkg::ADDR_W'(trial - divisor)
			: rse_pkg::ADDR_W'(trial);
	end

	assign full = (count_q == rse_pkg::CNT_W'(rse_pkg::MAX_ITEMS));

	assign sts.i_zero   = (i_q == '0);
	assign sts.lcg_last = (step_q == rse_pkg::STEP_W'(rse_pkg::LCG_CHUNKS - 1));
	assign sts.mod_last = (step_q == rse_pkg::STEP_W'(rse_pkg::RAND_BITS - 1));
	assign sts.k_last   = ((rse_pkg::CNT_W'(k_q) + rse_pkg::CNT_W'(1)) == count_q);

	// store port muxing
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[rse_pkg::ADDR_W-1:0];
		ram_wdata = {count_q[rse_pkg::ADDR_W-1:0], rse_pkg::ELEMENT_BITS'(in_value)};
		if (cmd.store && !full) begin
			ram_we = 1'b1;
		end else if (cmd.wr_i) begin
			ram_we    = 1'b1;
			ram_waddr = i_q;
			ram_wdata = ram_rdata;
		end else if (cmd.wr_j) begin
			ram_we    = 1'b1;
			ram_waddr = rem_q;
			ram_wdata = tmp_q;
		end
		if (cmd.rd_j) begin
			ram_raddr = rem_q;
		end else if (cmd.rd_k) begin
			ram_raddr = k_q;
		end else begin
			ram_raddr = i_q;
		end
	end

	rse_ram #(
		.WIDTH(rse_pkg::ENTRY_W),
		.DEPTH(rse_pkg::STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// generator and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q   <= '0;
			count_q <= '0;
		end else begin
			if (cfg_we) begin
				gen_q <= cfg_seed;
			end else if (cmd.gen_load) begin
				gen_q <= acc_q;
			end
			if (cmd.clr_count) begin
				count_q <= '0;
			end else if (cmd.store && !full) begin
				count_q <= count_q + rse_pkg::CNT_W'(1);
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			i_q <= rse_pkg::ADDR_W'(count_q - rse_pkg::CNT_W'(1));
			k_q <= '0;
		end
		if (cmd.wr_j) begin
			i_q <= i_q - rse_pkg::ADDR_W'(1);
		end
		if (cmd.lcg_init) begin
			acc_q  <= rse_pkg::LCG_ADD;
			step_q <= '0;
		end
		if (cmd.lcg_step) begin
			acc_q  <= acc_q + pp;
			step_q <= step_q + rse_pkg::STEP_W'(1);
		end
		if (cmd.gen_load) begin
			dvd_q  <= acc_q[rse_pkg::SEED_W-1 -: rse_pkg::RAND_BITS];
			rem_q  <= '0;
			step_q <= '0;
		end
		if (cmd.mod_step) begin
			dvd_q  <= {dvd_q[rse_pkg::RAND_BITS-2:0], 1'b0};
			rem_q  <= rem_next;
			step_q <= step_q + rse_pkg::STEP_W'(1);
		end
		if (cmd.rd_j) begin
			tmp_q <= ram_rdata;
		end
		if (cmd.out_load) begin
			out_value <= rse_pkg::VALUE_W'(ram_rdata[rse_pkg::ELEMENT_BITS-1:0]);
			out_index <= rse_pkg::INDEX_W'(ram_rdata[rse_pkg::ENTRY_W-1 -: rse_pkg::ADDR_W]);
			out_last  <= sts.k_last;
			k_q       <= k_q + rse_pkg::ADDR_W'(1);
		end
	end

endmodule

// ----- rtl/rse_ctrl.sv -----
// ----------------------------------------------------------------------------
// rse_ctrl: shuffle engine controller
// Sequences load, per-swap generator step, modulo and swap, then emission.
// ----------------------------------------------------------------------------
module rse_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output rse_pkg::rse_cmd_t cmd,
	input  rse_pkg::rse_sts_t sts
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_NEXT,
		ST_LCG,
		ST_GEN,
		ST_MOD,
		ST_RD_I,
		ST_RD_J,
		ST_WR_I,
		ST_WR_J,
		ST_EM_RD,
		ST_EM_LD
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.store = 1'b1;
					if (in_last) begin
						state_d = ST_PREP;
					end
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_NEXT;
			end
			ST_NEXT: begin
				cmd.lcg_init = 1'b1;
				state_d      = sts.i_zero ? ST_EM_RD : ST_LCG;
			end
			ST_LCG: begin
				cmd.lcg_step = 1'b1;
				if (sts.lcg_last) begin
					state_d = ST_GEN;
				end
			end
			ST_GEN: begin
				cmd.gen_load = 1'b1;
				state_d      = ST_MOD;
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) begin
					state_d = ST_RD_I;
				end
			end
			ST_RD_I: begin
				cmd.rd_i = 1'b1;
				state_d  = ST_RD_J;
			end
			ST_RD_J: begin
				cmd.rd_j = 1'b1;
				state_d  = ST_WR_I;
			end
			ST_WR_I: begin
				cmd.wr_i = 1'b1;
				state_d  = ST_WR_J;
			end
			ST_WR_J: begin
				cmd.wr_j = 1'b1;
				state_d  = ST_NEXT;
			end
			ST_EM_RD: begin
				// output slot is free now or empties at this edge
				if (!out_valid_q || out_ready) begin
					cmd.rd_k = 1'b1;
					state_d  = ST_EM_LD;
				end
			end
			ST_EM_LD: begin
				cmd.out_load = 1'b1;
				if (sts.k_last) begin
					cmd.clr_count = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					state_d = ST_EM_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/random_shuffle_engine.sv -----
// ----------------------------------------------------------------------------
// random_shuffle_engine: Fisher-Yates shuffle with a rand48 generator
// Loads a data set, shuffles it in place and streams it back out with the
// load position of every element.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake              payload
// cfg       in         cfg_valid / cfg_ready  seed[47:0]
// in        in         in_valid  / in_ready   value[31:0], last
// out       out        out_valid / out_ready  value_res[31:0], original_index[5:0], last_res
//
// Sequence: loading stores one element per accepted input. After the element
// marked last comes a setup step, then for a set of n elements (n-1 swaps) each
// swap runs a setup step, the generator steps (16-bit partial products), a
// commit, the modulo steps (one dividend bit each) and 4 store accesses on
// the single-read, single-write store. Emission reads, then loads each result.
// Reset: arst_n clears the controller, fill count and generator; the store
// holds no reset and only written entries are ever read.
// Stalls: out_ready low holds emission; the last result may still wait in the
// output register while loading of the next set proceeds.
//
module random_shuffle_engine (
	input  logic        clk,
	input  logic        arst_n,
	// seed write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [47:0] seed,
	// input transactions
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] value,
	input  logic        last,
	// result transactions
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] value_res,
	output logic [5:0]  original_index,
	output logic        last_res
);

	rse_pkg::rse_cmd_t cmd;
	rse_pkg::rse_sts_t sts;

	// seed writes land directly in the generator register
	assign cfg_ready = 1'b1;

	rse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (last),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	rse_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_we   (cfg_valid),
		.cfg_seed (seed),
		.in_value (value),
		.out_value(value_res),
		.out_index(original_index),
		.out_last (last_res)
	);

	// at most one store access per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.store, cmd.rd_i, cmd.rd_j, cmd.wr_i, cmd.wr_j, cmd.rd_k}))
		else $error("store port conflict");

	// a new result never overwrites one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid)
		else $error("output register overrun");

	// no shuffle or emission work while taking input
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !(cmd.lcg_step || cmd.mod_step || cmd.rd_k || cmd.wr_i))
		else $error("busy while accepting input");

	// the swap sequence runs read i, read j, write i, write j
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_i |=> cmd.rd_j ##1 cmd.wr_i ##1 cmd.wr_j)
		else $error("swap sequence broken");

endmodule
